### hdl/axis_aligned_rect_ray_hit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the rectangle ray hit block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AXIS_ALIGNED_RECT_RAY_HIT_MACROS_SVH
`define AXIS_ALIGNED_RECT_RAY_HIT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define AARH_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define AARH_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/aarh_pkg.sv
// ----------------------------------------------------------------------------
// Rectangle ray hit package
// Types, constants and helper functions shared by the block's modules.
// ----------------------------------------------------------------------------
package aarh_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int DATA_W = 32;
	localparam int UV_W = 17;
	localparam int UV_ONE_LOG2 = 16;
	localparam int MAT_W = 8;
	localparam int AXIS_W = 2;
	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = 3;
	localparam int PROD_W = 2 * DATA_W;
	localparam int PT_W = PROD_W + 1;

	localparam logic [UV_W-1:0] UV_ONE = UV_W'(1) << UV_ONE_LOG2;

	typedef logic signed [DATA_W-1:0] fix_t;

	localparam fix_t FIX_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam fix_t FIX_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	// Register map, word index on the configuration port.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_PLANE_AXIS   = 3'd0,
		REG_FIRST_LOW    = 3'd1,
		REG_FIRST_HIGH   = 3'd2,
		REG_SECOND_LOW   = 3'd3,
		REG_SECOND_HIGH  = 3'd4,
		REG_PLANE_OFFSET = 3'd5,
		REG_MATERIAL_ID  = 3'd6
	} reg_idx_t;

	// Plane selection codes.
	typedef enum logic [AXIS_W-1:0] {
		AXIS_XY = 2'd0,
		AXIS_XZ = 2'd1,
		AXIS_YZ = 2'd2
	} axis_t;

	// Coordinate indexes.
	localparam logic [1:0] IDX_X = 2'd0;
	localparam logic [1:0] IDX_Y = 2'd1;
	localparam logic [1:0] IDX_Z = 2'd2;

	typedef struct packed {
		logic [AXIS_W-1:0] plane_axis;
		fix_t              first_low;
		fix_t              first_high;
		fix_t              second_low;
		fix_t              second_high;
		fix_t              plane_offset;
		logic [MAT_W-1:0]  material_id;
	} cfg_t;

	typedef struct packed {
		fix_t origin_x;
		fix_t origin_y;
		fix_t origin_z;
		fix_t dir_x;
		fix_t dir_y;
		fix_t dir_z;
		fix_t t_min;
		fix_t t_max;
	} ray_t;

	typedef struct packed {
		logic             hit;
		fix_t             hit_t;
		logic [UV_W-1:0]  tex_u;
		logic [UV_W-1:0]  tex_v;
		fix_t             point_x;
		fix_t             point_y;
		fix_t             point_z;
		logic             front_face;
		logic [MAT_W-1:0] hit_material;
	} res_t;

	// Classified ray as it waits in the queue.
	typedef struct packed {
		fix_t [2:0]        org;
		fix_t [2:0]        dir;
		fix_t              t_lo;
		fix_t              t_hi;
		logic              alive;
		logic              neg;
		logic              front;
		logic [DATA_W:0]   num_mag;
		logic [DATA_W-1:0] den_mag;
	} qitem_t;

	// Sideband carried along the t divider.
	typedef struct packed {
		fix_t [2:0] org;
		fix_t [2:0] dir;
		fix_t       t_lo;
		fix_t       t_hi;
		logic       alive;
		logic       neg;
		logic       front;
	} tdiv_side_t;

	// Sideband carried along the surface coordinate divider.
	typedef struct packed {
		logic       hit;
		fix_t       t;
		fix_t [2:0] pt;
		logic       front;
		logic       span_u_nz;
	} uv_side_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic       ok;
		logic [1:0] n;
		logic [1:0] a;
		logic [1:0] b;
	} axis_map_t;

	// Normal axis and the two in-plane axes for each plane code.
	function automatic axis_map_t axis_map(input logic [AXIS_W-1:0] axis);
		axis_map_t m;
		m = '{ok: 1'b0, n: IDX_X, a: IDX_X, b: IDX_X};
		case (axis)
			AXIS_XY: m = '{ok: 1'b1, n: IDX_Z, a: IDX_X, b: IDX_Y};
			AXIS_XZ: m = '{ok: 1'b1, n: IDX_Y, a: IDX_X, b: IDX_Z};
			AXIS_YZ: m = '{ok: 1'b1, n: IDX_X, a: IDX_Y, b: IDX_Z};
			default: m = '{ok: 1'b0, n: IDX_X, a: IDX_X, b: IDX_X};
		endcase
		return m;
	endfunction

	// Clamp a wide signed value into the 32-bit signed range.
	function automatic fix_t sat_fix(input logic signed [PT_W-1:0] v);
		fix_t r;
		if ((&v[PT_W-1:DATA_W-1]) || !(|v[PT_W-1:DATA_W-1])) begin
			r = v[DATA_W-1:0];
		end else begin
			r = v[PT_W-1] ? FIX_MIN : FIX_MAX;
		end
		return r;
	endfunction

endpackage

### hdl/aarh_if.sv
// ----------------------------------------------------------------------------
// Rectangle ray hit stream interfaces
// Valid/ready channels for incoming rays and outgoing hit results.
// ----------------------------------------------------------------------------
interface aarh_ray_if;
	logic           valid;
	logic           ready;
	aarh_pkg::ray_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aarh_res_if;
	logic           valid;
	logic           ready;
	aarh_pkg::res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/axis_aligned_rect_ray_hit.sv
// Throughput: one ray per cycle while the result channel is not stalled, set by the t
// divider and the u/v dividers, which resolve one quotient bit per pipeline stage.
// A four-entry queue parts the classifying front end from the arithmetic pipeline.
// Reset (arst_n low) clears the configuration and control registers to zero and empties queue and pipeline.
// ----------------------------------------------------------------------------
// Rectangle ray hit top level
// Tests each ray against one configured axis-aligned rectangle.
// ----------------------------------------------------------------------------
module axis_aligned_rect_ray_hit #(
	parameter int FRAC_BITS   = aarh_pkg::FRAC_BITS_DEF,
	parameter int QUEUE_DEPTH = aarh_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aarh_pkg::ADDR_W-1:0] paddr,
	input  logic [aarh_pkg::DATA_W-1:0] pwdata,
	output logic [aarh_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	aarh_ray_if.sink                    rays,
	aarh_res_if.source                  hits
);

	aarh_pkg::cfg_t      cfg;
	aarh_pkg::qitem_t    push_item;
	aarh_pkg::qitem_t    head;
	aarh_pkg::q_status_t qs;
	logic                push;
	logic                pop;

	// Configuration registers.
	aarh_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// Front end classifies each ray into a queue entry.
	aarh_front u_front (
		.cfg (cfg),
		.rays(rays),
		.qs  (qs),
		.push(push),
		.item(push_item)
	);

	aarh_queue #(
		.DEPTH (QUEUE_DEPTH),
		.ITEM_T(aarh_pkg::qitem_t)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.head     (head),
		.st       (qs)
	);

	// Back end carries out the intersection arithmetic.
	aarh_back #(
		.FRAC_BITS(FRAC_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg),
		.head  (head),
		.qs    (qs),
		.pop   (pop),
		.hits  (hits)
	);

endmodule

### hdl/aarh_cfg_regs.sv
// ----------------------------------------------------------------------------
// Rectangle ray hit configuration registers
// APB-style register file holding the plane, bounds and material.
// ----------------------------------------------------------------------------
module aarh_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [aarh_pkg::ADDR_W-1:0] paddr,
	input  logic [aarh_pkg::DATA_W-1:0] pwdata,
	output logic [aarh_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output aarh_pkg::cfg_t              cfg
);

	aarh_pkg::cfg_t     cfg_q;
	aarh_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = aarh_pkg::reg_idx_t'(paddr[aarh_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; an index past the map is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				aarh_pkg::REG_PLANE_AXIS:   cfg_q.plane_axis   <= pwdata[aarh_pkg::AXIS_W-1:0];
				aarh_pkg::REG_FIRST_LOW:    cfg_q.first_low    <= pwdata;
				aarh_pkg::REG_FIRST_HIGH:   cfg_q.first_high   <= pwdata;
				aarh_pkg::REG_SECOND_LOW:   cfg_q.second_low   <= pwdata;
				aarh_pkg::REG_SECOND_HIGH:  cfg_q.second_high  <= pwdata;
				aarh_pkg::REG_PLANE_OFFSET: cfg_q.plane_offset <= pwdata;
				aarh_pkg::REG_MATERIAL_ID:  cfg_q.material_id  <= pwdata[aarh_pkg::MAT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read-back mux.
	always_comb begin
		unique case (idx)
			aarh_pkg::REG_PLANE_AXIS:   prdata = aarh_pkg::DATA_W'(cfg_q.plane_axis);
			aarh_pkg::REG_FIRST_LOW:    prdata = cfg_q.first_low;
			aarh_pkg::REG_FIRST_HIGH:   prdata = cfg_q.first_high;
			aarh_pkg::REG_SECOND_LOW:   prdata = cfg_q.second_low;
			aarh_pkg::REG_SECOND_HIGH:  prdata = cfg_q.second_high;
			aarh_pkg::REG_PLANE_OFFSET: prdata = cfg_q.plane_offset;
			aarh_pkg::REG_MATERIAL_ID:  prdata = aarh_pkg::DATA_W'(cfg_q.material_id);
			default:                    prdata = '0;
		endcase
	end

endmodule

### hdl/aarh_front.sv
// ----------------------------------------------------------------------------
// Rectangle ray hit front end
// Accepts rays, picks the normal axis and forms the t numerator and divisor.
// ----------------------------------------------------------------------------
module aarh_front (
	input  aarh_pkg::cfg_t      cfg,
	aarh_ray_if.sink            rays,
	input  aarh_pkg::q_status_t qs,
	output logic                push,
	output aarh_pkg::qitem_t    item
);

	aarh_pkg::axis_map_t         amap;
	aarh_pkg::fix_t [2:0]        org_v;
	aarh_pkg::fix_t [2:0]        dir_v;
	aarh_pkg::fix_t              on;
	aarh_pkg::fix_t              dn;
	logic [aarh_pkg::DATA_W:0]   num;
	logic [aarh_pkg::DATA_W:0]   num_neg;
	logic [aarh_pkg::DATA_W:0]   den_neg;

	// Accept whenever the queue has room.
	assign rays.ready = !qs.full;
	assign push       = rays.valid && rays.ready;

	// Origin and direction as vectors indexed by axis.
	assign org_v = {rays.data.origin_z, rays.data.origin_y, rays.data.origin_x};
	assign dir_v = {rays.data.dir_z, rays.data.dir_y, rays.data.dir_x};

	assign amap = aarh_pkg::axis_map(cfg.plane_axis);
	assign on   = org_v[amap.n];
	assign dn   = dir_v[amap.n];

	// Numerator k - origin_n and divisor dir_n in sign and magnitude form.
	assign num     = {cfg.plane_offset[aarh_pkg::DATA_W-1], cfg.plane_offset}
	               - {on[aarh_pkg::DATA_W-1], on};
	assign num_neg = (aarh_pkg::DATA_W+1)'(0) - num;
	assign den_neg = (aarh_pkg::DATA_W+1)'(0) - {dn[aarh_pkg::DATA_W-1], dn};

	always_comb begin
		item.org     = org_v;
		item.dir     = dir_v;
		item.t_lo    = rays.data.t_min;
		item.t_hi    = rays.data.t_max;
		item.alive   = amap.ok && (dn != '0);
		item.neg     = num[aarh_pkg::DATA_W] ^ dn[aarh_pkg::DATA_W-1];
		item.front   = dn[aarh_pkg::DATA_W-1];
		item.num_mag = num[aarh_pkg::DATA_W] ? num_neg : num;
		item.den_mag = dn[aarh_pkg::DATA_W-1] ? den_neg[aarh_pkg::DATA_W-1:0] : dn;
	end

endmodule

### hdl/aarh_queue.sv
// ----------------------------------------------------------------------------
// Rectangle ray hit queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "axis_aligned_rect_ray_hit_macros.svh"

module aarh_queue #(
	parameter int  DEPTH  = aarh_pkg::QUEUE_DEPTH_DEF,
	parameter type ITEM_T = aarh_pkg::qitem_t
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ITEM_T               push_item,
	input  logic                pop,
	output ITEM_T               head,
	output aarh_pkg::q_status_t st
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	ITEM_T            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign head     = mem_q[rd_ptr_q];
	assign st.full  = (cnt_q == CNT_W'(DEPTH));
	assign st.empty = (cnt_q == '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`AARH_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count past depth")
	`AARH_ASSERT_IMPLY(a_no_overflow, push, !st.full || pop, "push into full queue")
	`AARH_ASSERT_IMPLY(a_no_underflow, pop, !st.empty, "pop from empty queue")

endmodule

### hdl/aarh_div_pipe.sv
// ----------------------------------------------------------------------------
// Rectangle ray hit pipelined divider
// Restoring unsigned divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module aarh_div_pipe #(
	parameter int  NUM_W  = 48,
	parameter int  DEN_W  = 32,
	parameter int  QUO_W  = 17,
	parameter type SIDE_T = logic
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	input  SIDE_T            side_in,
	output logic             out_vld,
	output logic [QUO_W-1:0] quo,
	output SIDE_T            side_out
);

	// The upper numerator bits seed the remainder and must stay below den.
	logic [DEN_W-1:0] rem_s  [QUO_W];
	logic [QUO_W-1:0] low_s  [QUO_W];
	logic [DEN_W-1:0] den_s  [QUO_W];
	logic [QUO_W-1:0] quo_s  [QUO_W];
	SIDE_T            side_s [QUO_W];
	logic             vld_s  [QUO_W];

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W-1:0] rem_i;
		logic [QUO_W-1:0] low_i;
		logic [DEN_W-1:0] den_i;
		logic [QUO_W-1:0] quo_i;
		SIDE_T            side_i;
		logic             vld_i;
		logic [DEN_W:0]   trial;
		logic [DEN_W:0]   diff;
		logic             geq;

		if (k == 0) begin : g_first
			assign rem_i  = DEN_W'(num[NUM_W-1:QUO_W]);
			assign low_i  = num[QUO_W-1:0];
			assign den_i  = den;
			assign quo_i  = '0;
			assign side_i = side_in;
			assign vld_i  = in_vld;
		end else begin : g_next
			assign rem_i  = rem_s[k-1];
			assign low_i  = low_s[k-1];
			assign den_i  = den_s[k-1];
			assign quo_i  = quo_s[k-1];
			assign side_i = side_s[k-1];
			assign vld_i  = vld_s[k-1];
		end

		// Shift in the next numerator bit and try a subtract.
		assign trial = {rem_i, low_i[QUO_W-1-k]};
		assign diff  = trial - {1'b0, den_i};
		assign geq   = (trial >= {1'b0, den_i});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= geq ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				low_s[k]  <= low_i;
				den_s[k]  <= den_i;
				quo_s[k]  <= {quo_i[QUO_W-2:0], geq};
				side_s[k] <= side_i;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_i;
			end
		end
	end

	assign out_vld  = vld_s[QUO_W-1];
	assign quo      = quo_s[QUO_W-1];
	assign side_out = side_s[QUO_W-1];

endmodule

### hdl/aarh_back.sv
// ----------------------------------------------------------------------------
// Rectangle ray hit back end
// Divides for t, evaluates the hit point, checks bounds and forms u and v.
// ----------------------------------------------------------------------------
`include "axis_aligned_rect_ray_hit_macros.svh"

module aarh_back #(
	parameter int FRAC_BITS = aarh_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  aarh_pkg::cfg_t      cfg,
	input  aarh_pkg::qitem_t    head,
	input  aarh_pkg::q_status_t qs,
	output logic                pop,
	aarh_res_if.source          hits
);

	localparam int DW     = aarh_pkg::DATA_W;
	localparam int PROD_W = aarh_pkg::PROD_W;
	localparam int PT_W   = aarh_pkg::PT_W;
	localparam int CMP_W  = PROD_W + 1;
	localparam int TNUM_W = DW + 1 + FRAC_BITS;
	localparam int UNUM_W = DW + aarh_pkg::UV_ONE_LOG2;
	localparam int UV_W   = aarh_pkg::UV_W;
	localparam logic [DW-1:0] NEG_LIMIT = {1'b1, {(DW-1){1'b0}}};

	logic           adv;
	logic           out_vld_q;
	aarh_pkg::res_t out_q;

	// The whole pipeline moves when the output register is free or taken.
	assign adv        = !out_vld_q || hits.ready;
	assign pop        = adv && !qs.empty;
	assign hits.valid = out_vld_q;
	assign hits.data  = out_q;

	// t divider entry and quotient overflow check.
	logic [TNUM_W-1:0]    t_num;
	logic [CMP_W-1:0]     ovf_lhs;
	logic [CMP_W-1:0]     ovf_rhs;
	aarh_pkg::tdiv_side_t t_side_in;

	assign t_num   = {head.num_mag, {FRAC_BITS{1'b0}}};
	assign ovf_lhs = CMP_W'(t_num);
	assign ovf_rhs = {1'b0, head.den_mag, {DW{1'b0}}};

	always_comb begin
		t_side_in.org   = head.org;
		t_side_in.dir   = head.dir;
		t_side_in.t_lo  = head.t_lo;
		t_side_in.t_hi  = head.t_hi;
		t_side_in.alive = head.alive && (ovf_lhs < ovf_rhs);
		t_side_in.neg   = head.neg;
		t_side_in.front = head.front;
	end

	logic                 tq_vld;
	logic [DW-1:0]        tq;
	aarh_pkg::tdiv_side_t tq_side;

	aarh_div_pipe #(
		.NUM_W (TNUM_W),
		.DEN_W (DW),
		.QUO_W (DW),
		.SIDE_T(aarh_pkg::tdiv_side_t)
	) u_tdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (!qs.empty),
		.num     (t_num),
		.den     (head.den_mag),
		.side_in (t_side_in),
		.out_vld (tq_vld),
		.quo     (tq),
		.side_out(tq_side)
	);

	// Stage 1: apply the sign and range-check the quotient.
	logic                 vld_s1;
	aarh_pkg::fix_t       t_s1;
	aarh_pkg::tdiv_side_t side_s1;
	aarh_pkg::tdiv_side_t side_chk;
	logic                 t_ok;
	logic [DW-1:0]        tq_neg;

	assign tq_neg = DW'(0) - tq;
	assign t_ok   = tq_side.neg ? (tq <= NEG_LIMIT) : !tq[DW-1];

	always_comb begin
		side_chk       = tq_side;
		side_chk.alive = tq_side.alive && t_ok;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= tq_side.neg ? tq_neg : tq;
			side_s1 <= side_chk;
		end
	end

	// Stage 2: interval test and the three t * dir products.
	logic                     vld_s2;
	logic                     alive_s2;
	aarh_pkg::fix_t           t_s2;
	aarh_pkg::fix_t [2:0]     org_s2;
	logic                     front_s2;
	logic signed [PROD_W-1:0] prod_s2 [3];
	logic                     in_rng;

	assign in_rng = ($signed(side_s1.t_lo) < $signed(t_s1))
	             && ($signed(t_s1) < $signed(side_s1.t_hi));

	always_ff @(posedge clk) begin
		if (adv) begin
			alive_s2 <= side_s1.alive && in_rng;
			t_s2     <= t_s1;
			org_s2   <= side_s1.org;
			front_s2 <= side_s1.front;
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= PROD_W'($signed(t_s1)) * PROD_W'($signed(side_s1.dir[i]));
			end
		end
	end

	// Stage 3: hit point, origin plus floored scaled product.
	logic                   vld_s3;
	logic                   alive_s3;
	aarh_pkg::fix_t         t_s3;
	logic                   front_s3;
	logic signed [PT_W-1:0] pt_s3 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			alive_s3 <= alive_s2;
			t_s3     <= t_s2;
			front_s3 <= front_s2;
			for (int i = 0; i < 3; i++) begin
				pt_s3[i] <= PT_W'($signed(org_s2[i])) + PT_W'(prod_s2[i] >>> FRAC_BITS);
			end
		end
	end

	// Stage 4: bound checks, offsets from the low bounds, spans, saturation.
	aarh_pkg::axis_map_t    amap;
	logic signed [PT_W-1:0] ca;
	logic signed [PT_W-1:0] cb;
	logic signed [PT_W-1:0] du_full;
	logic signed [PT_W-1:0] dv_full;
	logic [DW:0]            span_u;
	logic [DW:0]            span_v;
	logic                   in_rect;

	assign amap    = aarh_pkg::axis_map(cfg.plane_axis);
	assign ca      = pt_s3[amap.a];
	assign cb      = pt_s3[amap.b];
	assign du_full = ca - PT_W'(cfg.first_low);
	assign dv_full = cb - PT_W'(cfg.second_low);
	assign span_u  = {cfg.first_high[DW-1], cfg.first_high}
	               - {cfg.first_low[DW-1], cfg.first_low};
	assign span_v  = {cfg.second_high[DW-1], cfg.second_high}
	               - {cfg.second_low[DW-1], cfg.second_low};
	assign in_rect = (ca >= PT_W'(cfg.first_low)) && (ca <= PT_W'(cfg.first_high))
	              && (cb >= PT_W'(cfg.second_low)) && (cb <= PT_W'(cfg.second_high));

	logic                 vld_s4;
	aarh_pkg::uv_side_t   uside_s4;
	logic                 vnz_s4;
	logic [DW-1:0]        du_s4;
	logic [DW-1:0]        dv_s4;
	logic [DW-1:0]        span_u_s4;
	logic [DW-1:0]        span_v_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			uside_s4.hit       <= alive_s3 && in_rect;
			uside_s4.t         <= t_s3;
			uside_s4.front     <= front_s3;
			uside_s4.span_u_nz <= (span_u != '0);
			for (int i = 0; i < 3; i++) begin
				uside_s4.pt[i] <= aarh_pkg::sat_fix(pt_s3[i]);
			end
			vnz_s4    <= (span_v != '0);
			du_s4     <= du_full[DW-1:0];
			dv_s4     <= dv_full[DW-1:0];
			span_u_s4 <= span_u[DW-1:0];
			span_v_s4 <= span_v[DW-1:0];
		end
	end

	// Valid bits of the stages between the dividers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= tq_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Surface coordinate dividers, offset * 65536 / span.
	logic               uq_vld;
	logic [UV_W-1:0]    uq;
	aarh_pkg::uv_side_t uq_side;
	logic               vq_vld;
	logic [UV_W-1:0]    vq;
	logic               vq_nz;

	aarh_div_pipe #(
		.NUM_W (UNUM_W),
		.DEN_W (DW),
		.QUO_W (UV_W),
		.SIDE_T(aarh_pkg::uv_side_t)
	) u_udiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s4),
		.num     ({du_s4, {aarh_pkg::UV_ONE_LOG2{1'b0}}}),
		.den     (span_u_s4),
		.side_in (uside_s4),
		.out_vld (uq_vld),
		.quo     (uq),
		.side_out(uq_side)
	);

	aarh_div_pipe #(
		.NUM_W (UNUM_W),
		.DEN_W (DW),
		.QUO_W (UV_W),
		.SIDE_T(logic)
	) u_vdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (vld_s4),
		.num     ({dv_s4, {aarh_pkg::UV_ONE_LOG2{1'b0}}}),
		.den     (span_v_s4),
		.side_in (vnz_s4),
		.out_vld (vq_vld),
		.quo     (vq),
		.side_out(vq_nz)
	);

	// Output register; a miss reports all fields as zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			if (uq_side.hit) begin
				out_q.hit          <= 1'b1;
				out_q.hit_t        <= uq_side.t;
				out_q.tex_u        <= uq_side.span_u_nz ? uq : '0;
				out_q.tex_v        <= vq_nz ? vq : '0;
				out_q.point_x      <= uq_side.pt[0];
				out_q.point_y      <= uq_side.pt[1];
				out_q.point_z      <= uq_side.pt[2];
				out_q.front_face   <= uq_side.front;
				out_q.hit_material <= cfg.material_id;
			end else begin
				out_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= uq_vld && vq_vld;
		end
	end

	// Conditions checked on the output register.
	logic miss_clean;
	logic uv_in_range;

	assign miss_clean  = (out_q.hit_t == '0) && (out_q.tex_u == '0)
	                  && (out_q.hit_material == '0);
	assign uv_in_range = (out_q.tex_u <= aarh_pkg::UV_ONE) && (out_q.tex_v <= aarh_pkg::UV_ONE);

	`AARH_ASSERT_IMPLY(a_div_aligned, uq_vld, vq_vld, "surface dividers out of step")
	`AARH_ASSERT_IMPLY(a_miss_zero, out_vld_q && !out_q.hit, miss_clean, "miss with nonzero fields")
	`AARH_ASSERT_IMPLY(a_uv_range, out_vld_q && out_q.hit, uv_in_range, "surface coordinate above one")

endmodule

### verif/tb_axis_aligned_rect_ray_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle ray hit testbench
// Writes the rectangle registers over the configuration port in several
// phases and streams directed and random rays through the block, with random
// gaps on both channels. Every result is checked field by field against a
// typed-in value or a fixed-point intersection predictor held in this file.
// ----------------------------------------------------------------------------
module tb_axis_aligned_rect_ray_hit;
	import aarh_pkg::*;

	localparam int FRAC = FRAC_BITS_DEF;
	localparam logic [31:0] ONE = 32'h0001_0000;
	localparam logic [31:0] AXIS_NONE = 32'd3;
	localparam int REG_UNUSED = 7;
	localparam int N_RESET_ROWS = 2;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 80;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	aarh_ray_if rays ();
	aarh_res_if hits ();

	axis_aligned_rect_ray_hit dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.rays(rays.sink), .hits(hits.source)
	);

	always #4 clk = ~clk;

	cfg_t rect_cfg;
	res_t pending_hits[$];
	int fail_count = 0;
	bit quiet = 1'b0;

	// A table row: a ray and, where it is obvious, its typed-in result.
	typedef struct {
		ray_t ray;
		bit   typed;
		res_t res;
	} row_t;

	// Saturate a wide value into the signed 32-bit range.
	function automatic fix_t clamp32(longint v);
		if (v > 64'sd2147483647) return FIX_MAX;
		if (v < -64'sd2147483648) return FIX_MIN;
		return v[31:0];
	endfunction

	// Surface coordinate, 65536 meaning one full span.
	function automatic logic [UV_W-1:0] surface_pos(longint c, longint lo, longint hi);
		longint span;
		longint q;
		span = hi - lo;
		if (span <= 0) return '0;
		q = ((c - lo) * 64'sd65536) / span;
		return q[UV_W-1:0];
	endfunction

	// Intersection of one ray with the configured rectangle.
	function automatic res_t predict_hit(ray_t r);
		res_t h;
		longint o[3], d[3], p[3];
		longint num, t, ca, cb, tmin, tmax;
		int n, a, b;
		h = '0;
		case (rect_cfg.plane_axis)
			AXIS_XY: begin n = 2; a = 0; b = 1; end
			AXIS_XZ: begin n = 1; a = 0; b = 2; end
			AXIS_YZ: begin n = 0; a = 1; b = 2; end
			default: return h;
		endcase
		o[0] = r.origin_x; o[1] = r.origin_y; o[2] = r.origin_z;
		d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
		tmin = r.t_min;
		tmax = r.t_max;
		if (d[n] == 0) return h;
		num = longint'(rect_cfg.plane_offset) - o[n];
		t = (num * (64'sd1 <<< FRAC)) / d[n];
		if (t > 64'sd2147483647 || t < -64'sd2147483648) return h;
		if (!(tmin < t && t < tmax)) return h;
		for (int i = 0; i < 3; i++) p[i] = o[i] + ((t * d[i]) >>> FRAC);
		ca = p[a];
		cb = p[b];
		if (ca < rect_cfg.first_low || ca > rect_cfg.first_high ||
				cb < rect_cfg.second_low || cb > rect_cfg.second_high) return h;
		h.hit = 1'b1;
		h.hit_t = t[31:0];
		h.tex_u = surface_pos(ca, rect_cfg.first_low, rect_cfg.first_high);
		h.tex_v = surface_pos(cb, rect_cfg.second_low, rect_cfg.second_high);
		h.point_x = clamp32(p[0]);
		h.point_y = clamp32(p[1]);
		h.point_z = clamp32(p[2]);
		h.front_face = d[n] < 0;
		h.hit_material = rect_cfg.material_id;
		return h;
	endfunction

	// Register write: setup cycle, then access cycle; pready is always high.
	task automatic reg_write(int idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PLANE_AXIS:   rect_cfg.plane_axis = value[AXIS_W-1:0];
			REG_FIRST_LOW:    rect_cfg.first_low = value;
			REG_FIRST_HIGH:   rect_cfg.first_high = value;
			REG_SECOND_LOW:   rect_cfg.second_low = value;
			REG_SECOND_HIGH:  rect_cfg.second_high = value;
			REG_PLANE_OFFSET: rect_cfg.plane_offset = value;
			REG_MATERIAL_ID:  rect_cfg.material_id = value[MAT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Present one request and hold it until accepted.
	task automatic send_ray(ray_t r, res_t res);
		if (!quiet && $urandom_range(99) < 11) begin
			rays.valid <= 1'b0;
			@(posedge clk);
		end
		rays.valid <= 1'b1;
		rays.data <= r;
		do @(posedge clk); while (!rays.ready);
		pending_hits.push_back(res);
	endtask

	function automatic int small_coord();
		return int'($urandom_range(0, 1 << 21)) - (1 << 20);
	endfunction

	function automatic longint pick_between(longint lo, longint hi);
		longint unsigned rr;
		rr = {$urandom, $urandom};
		if (lo > hi) return small_coord();
		return lo + longint'(rr % longint'(hi - lo + 1));
	endfunction

	// A ray aimed at a point of the rectangle, or pure noise now and then.
	function automatic ray_t aimed_ray();
		ray_t r;
		longint pt[3], d[3], o[3], tq;
		int n, a, b;
		if ($urandom_range(99) < 25) begin
			r = {$urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			return r;
		end
		case (rect_cfg.plane_axis)
			AXIS_XZ: begin n = 1; a = 0; b = 2; end
			AXIS_YZ: begin n = 0; a = 1; b = 2; end
			default: begin n = 2; a = 0; b = 1; end
		endcase
		pt[n] = rect_cfg.plane_offset;
		pt[a] = pick_between(rect_cfg.first_low, rect_cfg.first_high);
		pt[b] = pick_between(rect_cfg.second_low, rect_cfg.second_high);
		tq = $urandom_range(1 << 12, 1 << 20);
		for (int i = 0; i < 3; i++) begin
			d[i] = int'($urandom_range(0, 1 << 19)) - (1 << 18);
			if ($urandom_range(9) == 0) d[i] = 0;
		end
		if (d[n] == 0 && $urandom_range(3) != 0) d[n] = -longint'(ONE);
		for (int i = 0; i < 3; i++) o[i] = pt[i] - ((tq * d[i]) >>> FRAC);
		r.origin_x = o[0][31:0];
		r.origin_y = o[1][31:0];
		r.origin_z = o[2][31:0];
		r.dir_x = d[0][31:0];
		r.dir_y = d[1][31:0];
		r.dir_z = d[2][31:0];
		case ($urandom_range(4))
			0: begin r.t_min = 32'(tq - 1); r.t_max = 32'(tq + 1); end
			1: begin r.t_min = 32'(tq); r.t_max = FIX_MAX; end
			2: begin r.t_min = FIX_MIN; r.t_max = $urandom; end
			default: begin r.t_min = '0; r.t_max = FIX_MAX; end
		endcase
		return r;
	endfunction

	task automatic report_field(string name, longint want, longint got);
		fail_count++;
		if (fail_count <= 10)
			$display("mismatch %s: expected %0h, got %0h", name, want, got);
	endtask

	// Result side: random stalls, and every accepted result is checked.
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && hits.valid && hits.ready) begin
			got = hits.data;
			if (pending_hits.size() == 0) begin
				report_field("unexpected result", 0, got.hit);
			end else begin
				want = pending_hits.pop_front();
				if (got.hit !== want.hit) report_field("hit", want.hit, got.hit);
				if (got.hit_t !== want.hit_t) report_field("hit_t", want.hit_t, got.hit_t);
				if (got.tex_u !== want.tex_u) report_field("tex_u", want.tex_u, got.tex_u);
				if (got.tex_v !== want.tex_v) report_field("tex_v", want.tex_v, got.tex_v);
				if (got.point_x !== want.point_x)
					report_field("point_x", want.point_x, got.point_x);
				if (got.point_y !== want.point_y)
					report_field("point_y", want.point_y, got.point_y);
				if (got.point_z !== want.point_z)
					report_field("point_z", want.point_z, got.point_z);
				if (got.front_face !== want.front_face)
					report_field("front_face", want.front_face, got.front_face);
				if (got.hit_material !== want.hit_material)
					report_field("hit_material", want.hit_material, got.hit_material);
			end
		end
		hits.ready <= quiet || ($urandom_range(99) >= 11);
	end

	initial begin
		#(8 * 400000);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		row_t rows[$];
		row_t row;
		res_t miss;
		rays.valid = 1'b0;
		rays.data = '0;
		hits.ready = 1'b0;
		rect_cfg = '0;
		miss = '0;

		// After reset the rectangle is the single point at the origin, z = 0.
		row.typed = 1'b1;
		row.ray = '{origin_x: 0, origin_y: 0, origin_z: -ONE, dir_x: 0, dir_y: 0,
			dir_z: ONE, t_min: 0, t_max: 2 * ONE};
		row.res = '0;
		row.res.hit = 1'b1;
		row.res.hit_t = ONE;
		rows.push_back(row);
		// Zero normal direction is a miss.
		row.ray.dir_z = 0;
		row.res = miss;
		rows.push_back(row);

		// Rectangle x in [-4,4], y in [-2,2] at z = 1, checked by the predictor.
		row.typed = 1'b0;
		row.ray = '{origin_x: 0, origin_y: 0, origin_z: 0, dir_x: 0, dir_y: 0,
			dir_z: ONE, t_min: 0, t_max: FIX_MAX};
		rows.push_back(row);
		row.ray.origin_z = 4 * ONE; row.ray.dir_z = -ONE;
		rows.push_back(row);
		row.ray.origin_x = 4 * ONE; row.ray.origin_y = 2 * ONE;
		rows.push_back(row);
		row.ray.origin_x = -4 * ONE; row.ray.origin_y = -2 * ONE;
		rows.push_back(row);
		row.ray.origin_x = 4 * ONE + 1;
		rows.push_back(row);
		// t exactly on either strict bound.
		row.ray = '{origin_x: 0, origin_y: 0, origin_z: 0, dir_x: ONE, dir_y: 0,
			dir_z: ONE, t_min: ONE, t_max: FIX_MAX};
		rows.push_back(row);
		row.ray.t_min = 0; row.ray.t_max = ONE;
		rows.push_back(row);
		// Overflowing t from a tiny normal direction.
		row.ray = '{origin_x: 0, origin_y: 0, origin_z: FIX_MIN, dir_x: 0, dir_y: 0,
			dir_z: 1, t_min: FIX_MIN, t_max: FIX_MAX};
		rows.push_back(row);
		// Hit behind the origin with a negative interval.
		row.ray = '{origin_x: 0, origin_y: 0, origin_z: 3 * ONE, dir_x: 0, dir_y: 0,
			dir_z: ONE, t_min: FIX_MIN, t_max: 0};
		rows.push_back(row);
		// Extreme origins and directions, saturated hit points.
		row.ray = '{origin_x: FIX_MAX, origin_y: FIX_MIN, origin_z: FIX_MIN,
			dir_x: FIX_MAX, dir_y: FIX_MIN, dir_z: FIX_MAX, t_min: FIX_MIN, t_max: FIX_MAX};
		rows.push_back(row);
		row.ray = '{origin_x: 0, origin_y: 0, origin_z: ONE + 1, dir_x: FIX_MAX,
			dir_y: FIX_MIN, dir_z: FIX_MIN, t_min: FIX_MIN, t_max: FIX_MAX};
		rows.push_back(row);
		row.ray = '{origin_x: -1, origin_y: -1, origin_z: -1, dir_x: -1, dir_y: -1,
			dir_z: -1, t_min: -1, t_max: -1};
		rows.push_back(row);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		foreach (rows[i]) begin
			if (i == N_RESET_ROWS) begin
				rays.valid <= 1'b0;
				drain();
				reg_write(REG_FIRST_LOW, -4 * ONE);
				reg_write(REG_FIRST_HIGH, 4 * ONE);
				reg_write(REG_SECOND_LOW, -2 * ONE);
				reg_write(REG_SECOND_HIGH, 2 * ONE);
				reg_write(REG_PLANE_OFFSET, ONE);
				reg_write(REG_MATERIAL_ID, 8'hA5);
			end
			send_ray(rows[i].ray, rows[i].typed ? rows[i].res : predict_hit(rows[i].ray));
		end

		// Random phases, each with its own rectangle.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			rays.valid <= 1'b0;
			drain();
			quiet = (ph == 2);
			case (ph)
				0: begin
					reg_write(REG_PLANE_AXIS, AXIS_XY);
					reg_write(REG_FIRST_LOW, -8 * ONE);
					reg_write(REG_FIRST_HIGH, 8 * ONE);
					reg_write(REG_SECOND_LOW, -8 * ONE);
					reg_write(REG_SECOND_HIGH, 8 * ONE);
					reg_write(REG_PLANE_OFFSET, 0);
				end
				1: begin
					reg_write(REG_PLANE_AXIS, AXIS_XZ);
					reg_write(REG_FIRST_LOW, FIX_MIN);
					reg_write(REG_FIRST_HIGH, FIX_MAX);
					reg_write(REG_SECOND_LOW, FIX_MIN);
					reg_write(REG_SECOND_HIGH, FIX_MAX);
					reg_write(REG_PLANE_OFFSET, FIX_MAX);
				end
				3: reg_write(REG_PLANE_AXIS, AXIS_NONE);
				4: begin
					reg_write(REG_PLANE_AXIS, AXIS_XY);
					reg_write(REG_FIRST_LOW, ONE);
					reg_write(REG_FIRST_HIGH, -ONE);
				end
				5: begin
					reg_write(REG_PLANE_AXIS, AXIS_YZ);
					reg_write(REG_FIRST_LOW, small_coord() - (1 << 20));
					reg_write(REG_FIRST_HIGH, small_coord() + (1 << 20));
					reg_write(REG_SECOND_LOW, ONE / 2);
					reg_write(REG_SECOND_HIGH, ONE / 2);
					reg_write(REG_PLANE_OFFSET, FIX_MIN);
				end
				6: begin
					reg_write(REG_PLANE_AXIS, $urandom_range(0, 3));
					reg_write(REG_FIRST_LOW, $urandom);
					reg_write(REG_FIRST_HIGH, $urandom);
					reg_write(REG_SECOND_LOW, $urandom);
					reg_write(REG_SECOND_HIGH, $urandom);
					reg_write(REG_PLANE_OFFSET, $urandom);
				end
				default: begin
					reg_write(REG_PLANE_AXIS, (ph == 2) ? AXIS_YZ : AXIS_XY);
					reg_write(REG_FIRST_LOW, small_coord() - (1 << 20));
					reg_write(REG_FIRST_HIGH, small_coord() + (1 << 20));
					reg_write(REG_SECOND_LOW, small_coord() - (1 << 20));
					reg_write(REG_SECOND_HIGH, small_coord() + (1 << 20));
					reg_write(REG_PLANE_OFFSET, small_coord());
				end
			endcase
			reg_write(REG_MATERIAL_ID, (ph == 1) ? 8'hFF : (ph == 7) ? 8'h00 : $urandom);
			reg_write(REG_UNUSED, $urandom);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				ray_t r;
				r = aimed_ray();
				send_ray(r, predict_hit(r));
			end
		end
		rays.valid <= 1'b0;
		quiet = 1'b0;

		while (pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
